// ===== hdl/positional_array_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional array table
// Concurrent assertion wrappers; these expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_TABLE_ASSERT_SVH
`define POSITIONAL_ARRAY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define PAT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("positional array table assertion failed");
// If the trigger holds, the consequence must hold in the following cycle.
`define PAT_ASSERT_NEXT(label, clk, rst, trig, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (conseq)) \
      else $error("positional array table assertion failed");
`else
`define PAT_ASSERT(label, clk, rst, prop)
`define PAT_ASSERT_NEXT(label, clk, rst, trig, conseq)
`endif
`endif

// ===== hdl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array table package
// Shared widths, operation and status codes, and control types.
// ----------------------------------------------------------------------------
package pat_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 16;

   // Request and response field widths
   localparam int MODE_W      = 2;
   localparam int POS_W       = 4;
   localparam int IN_VALUE_W  = 16;
   localparam int IDX_OUT_W   = 4;
   localparam int OUT_VALUE_W = 16;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_REPORT = 2'd3;

   // Response status
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

   // Cell operations
   localparam int CELL_OP_W = 2;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
   localparam logic [CELL_OP_W-1:0] CELL_INSERT = 2'd1;
   localparam logic [CELL_OP_W-1:0] CELL_DELETE = 2'd2;
   localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 2'd3;

   // Scan unit control
   typedef struct packed {
      logic step;    // take the head entry this cycle
      logic first;   // head entry is table index zero
   } scan_ctrl_type;

endpackage

// ===== hdl/pat_if.sv =====
// ----------------------------------------------------------------------------
// Positional array table channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface pat_req_if;
   logic                           valid;
   logic                           ready;
   logic [pat_pkg::MODE_W-1:0]     mode;
   logic [pat_pkg::POS_W-1:0]      position;
   logic [pat_pkg::IN_VALUE_W-1:0] value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface pat_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [pat_pkg::IDX_OUT_W-1:0]   found_index;
   logic [pat_pkg::OUT_VALUE_W-1:0] min_value;
   logic [pat_pkg::OUT_VALUE_W-1:0] max_value;
   logic [pat_pkg::COUNT_OUT_W-1:0] entry_count;
   logic [pat_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output found, output found_index, output min_value,
                   output max_value, output entry_count, output status, input ready);
   modport sink   (input valid, input found, input found_index, input min_value,
                   input max_value, input entry_count, input status, output ready);
endinterface

// ===== hdl/pat_cell.sv =====
// ----------------------------------------------------------------------------
// Positional array table cell
// One table entry; shifts up, shifts down or rotates with its neighbors.
// ----------------------------------------------------------------------------
module pat_cell #(
   parameter int INDEX      = 0,
   parameter int CW         = 5,
   parameter int VALUE_BITS = pat_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic [pat_pkg::CELL_OP_W-1:0] op,
   input  logic [CW-1:0]                 pos,
   input  logic [CW-1:0]                 last,
   input  logic [VALUE_BITS-1:0]         load_value,
   input  logic [VALUE_BITS-1:0]         prev_entry,
   input  logic [VALUE_BITS-1:0]         next_entry,
   input  logic [VALUE_BITS-1:0]         head_entry,
   output logic [VALUE_BITS-1:0]         entry
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (op)
         pat_pkg::CELL_INSERT: begin
            if (IDX > pos) begin
               entry_in = prev_entry;
            end else if (IDX == pos) begin
               entry_in = load_value;
            end
         end
         pat_pkg::CELL_DELETE: begin
            if (IDX >= pos) begin
               entry_in = next_entry;
            end
         end
         pat_pkg::CELL_ROTATE: begin
            // Advance toward the head; the last valid cell takes the head entry.
            if (IDX < last) begin
               entry_in = next_entry;
            end else if (IDX == last) begin
               entry_in = head_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/pat_scan.sv =====
// ----------------------------------------------------------------------------
// Positional array table scan unit
// Accumulates search match and min/max over entries passing the chain head.
// ----------------------------------------------------------------------------
module pat_scan #(
   parameter int VALUE_BITS = pat_pkg::VALUE_BITS_DEFAULT,
   parameter int IW         = 4
) (
   input  logic                   clock,
   input  pat_pkg::scan_ctrl_type ctrl,
   input  logic [VALUE_BITS-1:0]  head,
   input  logic [VALUE_BITS-1:0]  key,
   input  logic [IW-1:0]          step_index,
   output logic                   found_in,
   output logic [IW-1:0]          index_in,
   output logic [VALUE_BITS-1:0]  min_in,
   output logic [VALUE_BITS-1:0]  max_in
);

   logic                  found_ff;
   logic [IW-1:0]         index_ff;
   logic [VALUE_BITS-1:0] min_ff;
   logic [VALUE_BITS-1:0] max_ff;
   logic                  match;

   assign match = (head == key);

   always_comb begin
      if (ctrl.first) begin
         found_in = match;
         index_in = step_index;
         min_in   = head;
         max_in   = head;
      end else begin
         // Keep the lowest matching index.
         found_in = found_ff | match;
         index_in = found_ff ? index_ff : step_index;
         min_in   = (head < min_ff) ? head : min_ff;
         max_in   = (head > max_ff) ? head : max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         found_ff <= found_in;
         index_ff <= index_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

endmodule

// ===== hdl/positional_array_table.sv =====
// ----------------------------------------------------------------------------
// Positional array table
// Ordered table of DEPTH entries with search, insert, delete and min/max.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-----------------------------------
//   req_ch   | in  | valid/ready, taken when | mode, position, value
//            |     | both high at clock edge |
//   rsp_ch   | out | valid/ready             | found, found_index, min_value,
//            |     |                         | max_value, entry_count, status
//
// Insert and delete act in the cycle the request is taken: cells from the
// position upward load the new value or shift with their neighbor; a request
// that fails a check leaves the cells unchanged. Search and report rotate the
// valid entries once through the chain head, one entry per cycle, past the
// single scan unit, and land back in place.
// Synchronous reset empties the table and drops any pending response; entry
// storage is not cleared. A new request is taken while idle when the response
// register is empty or is being drained in the same cycle.
//
module positional_array_table #(
   parameter int DEPTH      = pat_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = pat_pkg::VALUE_BITS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   pat_req_if.sink  req_ch,
   pat_rsp_if.source rsp_ch
);

   `include "positional_array_table_assert.svh"

   localparam int CW = $clog2(DEPTH + 1);                       // count width
   localparam int IW = $clog2(DEPTH);                           // index width
   localparam int PW = (CW > pat_pkg::POS_W) ? CW : pat_pkg::POS_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // Control
   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] step_ff, step_in;
   logic [pat_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [VALUE_BITS-1:0]      key_ff, key_in;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [pat_pkg::IDX_OUT_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [pat_pkg::OUT_VALUE_W-1:0]   rsp_min_ff, rsp_min_in;
   logic [pat_pkg::OUT_VALUE_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [pat_pkg::COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [pat_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                          req_acc;
   logic                          out_free;
   logic                          empty;
   logic                          full;
   logic [PW-1:0]                 pos_wide;
   logic [PW-1:0]                 cnt_wide;
   logic [CW-1:0]                 last;
   logic [pat_pkg::CELL_OP_W-1:0] cell_op;
   logic [VALUE_BITS-1:0]         load_value;
   logic [VALUE_BITS-1:0]         entry_w [DEPTH];

   pat_pkg::scan_ctrl_type scan_ctrl;
   logic                   scan_found;
   logic [IW-1:0]          scan_index;
   logic [VALUE_BITS-1:0]  scan_min;
   logic [VALUE_BITS-1:0]  scan_max;

   assign req_acc    = req_ch.valid & req_ch.ready;
   assign out_free   = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) & out_free;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign pos_wide   = PW'(req_ch.position);
   assign cnt_wide   = PW'(count_ff);
   assign last       = count_ff - 1'b1;
   assign load_value = VALUE_BITS'(req_ch.value);

   // Chain of cells: each one sees its two neighbors and the head.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0] prev_w;
      logic [VALUE_BITS-1:0] next_w;

      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid_prev
         assign prev_w = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid_next
         assign next_w = entry_w[i+1];
      end

      pat_cell #(
         .INDEX      (i),
         .CW         (CW),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (CW'(req_ch.position)),
         .last       (last),
         .load_value (load_value),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .head_entry (entry_w[0]),
         .entry      (entry_w[i])
      );
   end

   // The entry at the head during scan step k is the one at table index k.
   pat_scan #(
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW)
   ) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .head       (entry_w[0]),
      .key        (key_ff),
      .step_index (step_ff),
      .found_in   (scan_found),
      .index_in   (scan_index),
      .min_in     (scan_min),
      .max_in     (scan_max)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      cell_op       = pat_pkg::CELL_HOLD;
      scan_ctrl     = '0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_index_in  = '0;
               rsp_min_in    = '0;
               rsp_max_in    = '0;
               rsp_status_in = pat_pkg::STATUS_OK;
               case (req_ch.mode) inside
                  pat_pkg::MODE_INSERT: begin
                     if (full) begin
                        rsp_status_in = pat_pkg::STATUS_FULL;
                     end else if (pos_wide > cnt_wide) begin
                        rsp_status_in = pat_pkg::STATUS_BADPOS;
                     end else begin
                        cell_op  = pat_pkg::CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pat_pkg::MODE_DELETE: begin
                     if (empty) begin
                        rsp_status_in = pat_pkg::STATUS_EMPTY;
                     end else if (pos_wide >= cnt_wide) begin
                        rsp_status_in = pat_pkg::STATUS_BADPOS;
                     end else begin
                        cell_op  = pat_pkg::CELL_DELETE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  pat_pkg::MODE_SEARCH, pat_pkg::MODE_REPORT: begin
                     if (empty) begin
                        rsp_status_in = pat_pkg::STATUS_EMPTY;
                     end else begin
                        // Hold off the response until the rotation is done.
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        step_in      = '0;
                        mode_in      = req_ch.mode;
                        key_in       = load_value;
                     end
                  end
               endcase
               rsp_count_in = pat_pkg::COUNT_OUT_W'(count_in);
            end
         end
         ST_SCAN: begin
            cell_op         = pat_pkg::CELL_ROTATE;
            scan_ctrl.step  = 1'b1;
            scan_ctrl.first = (step_ff == '0);
            if (CW'(step_ff) == last) begin
               // Last valid entry at the head: the table is back in order.
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = (mode_ff == pat_pkg::MODE_SEARCH) & scan_found;
               rsp_index_in  = rsp_found_in ? pat_pkg::IDX_OUT_W'(scan_index) : '0;
               rsp_min_in    = (mode_ff == pat_pkg::MODE_REPORT) ?
                               pat_pkg::OUT_VALUE_W'(scan_min) : '0;
               rsp_max_in    = (mode_ff == pat_pkg::MODE_REPORT) ?
                               pat_pkg::OUT_VALUE_W'(scan_max) : '0;
               rsp_count_in  = pat_pkg::COUNT_OUT_W'(count_ff);
               rsp_status_in = pat_pkg::STATUS_OK;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_index = rsp_index_ff;
   assign rsp_ch.min_value   = rsp_min_ff;
   assign rsp_ch.max_value   = rsp_max_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.status      = rsp_status_ff;

   `PAT_ASSERT(a_count_in_range, clock, reset, count_ff <= CW'(DEPTH))
   `PAT_ASSERT(a_scan_step_valid, clock, reset, (state_ff == ST_SCAN) |-> ((count_ff != '0) && (CW'(step_ff) < count_ff)))
   `PAT_ASSERT(a_scan_rsp_empty, clock, reset, (state_ff == ST_SCAN) |-> !rsp_valid_ff)
   `PAT_ASSERT_NEXT(a_insert_grows, clock, reset, req_acc && (req_ch.mode == pat_pkg::MODE_INSERT) && !full && (pos_wide <= cnt_wide), count_ff == $past(count_ff) + 1'b1)

endmodule
